>>> hdl/bed_pkg.sv
`default_nettype none

package bed_pkg;

  // Parser modes of the escape decoder.
  typedef enum logic [2:0] {
    MODE_TEXT   = 3'd0,
    MODE_OPEN   = 3'd1,
    MODE_SPACE  = 3'd2,
    MODE_NUMBER = 3'd3,
    MODE_SKIP   = 3'd4
  } bed_mode_t;

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    bed_mode_t  mode;
    logic [7:0] acc;
    logic       neg;
  } bed_state_t;

  // Decoded result of one byte.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
  } bed_result_t;

  localparam bed_state_t STATE_RESET = '{mode: MODE_TEXT, acc: 8'd0, neg: 1'b0};

endpackage

`default_nettype wire

>>> hdl/bracket_escape_decoder_unit.sv
`default_nettype none

// Angle-bracket escape decoder. Each request carries one text byte and a flag
// that marks the final byte of a string. Plain bytes pass through; "<<" gives
// a literal '<'; '<' followed by a decimal number (optional leading
// whitespace and sign) gives that number modulo 256, with a missing number
// giving zero, and everything after the number up to the closing '>' is
// dropped. A request marked last closes any escape still open and returns the
// parser to plain text. A request gives zero or one result byte. The block
// takes one request per clock cycle at a sustained rate while the result side
// is not stalled: the whole decode of a byte is a short piece of logic between
// the input register and the result register, and the parser state updates as
// each byte leaves the input register. A byte that gives a result passes
// through the input register and then the result register to the result port.
module bracket_escape_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       is_last,
  output logic            data_valid,
  input  wire logic       data_ready,
  output logic [7:0]      data_byte
);

  // Input register.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;

  // Parser state.
  bed_pkg::bed_state_t  state;
  bed_pkg::bed_state_t  state_next;
  bed_pkg::bed_result_t result;

  logic advance;

  // The held byte is decoded once the result register is free or is being
  // emptied in this same cycle.
  assign advance    = hold_valid && (!data_valid || data_ready);
  assign text_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (text_ready) begin
      hold_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_ready && text_valid) begin
      hold_byte <= text_byte;
      hold_last <= is_last;
    end
  end

  bed_step u_step (
    .state      (state),
    .text_byte  (hold_byte),
    .is_last    (hold_last),
    .state_next (state_next),
    .result     (result)
  );

  // The parser state only moves when a byte is actually decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bed_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register. It is refilled whenever it is free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else if (!data_valid || data_ready) begin
      data_valid <= advance && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      data_byte <= result.data;
    end
  end

  // A decoded byte marked last always leaves the parser in plain text mode.
  assert property (@(posedge clk) disable iff (rst)
    advance && hold_last |=> state == bed_pkg::STATE_RESET)
    else $error("parser not reset after the final byte of a string");

  // A byte held back by a stalled result stays in the input register.
  assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_byte) && $stable(hold_last))
    else $error("held byte lost while the result side stalled");

  // The input side is only refused while both registers are occupied.
  assert property (@(posedge clk) disable iff (rst)
    !text_ready |-> hold_valid && data_valid && !data_ready)
    else $error("request refused without a stall");

  // The parser state does not move while no byte is decoded.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("parser state changed without a decoded byte");

endmodule

`default_nettype wire

>>> hdl/bed_step.sv
`default_nettype none

// Decodes one byte against the current parser state.
module bed_step (
  input  wire bed_pkg::bed_state_t  state,
  input  wire logic [7:0]           text_byte,
  input  wire logic                 is_last,
  output bed_pkg::bed_state_t       state_next,
  output bed_pkg::bed_result_t      result
);

  logic              is_digit;
  logic              is_blank;
  logic [7:0]        digit;
  logic [7:0]        close_value;
  bed_pkg::bed_mode_t mode_step;
  logic [7:0]        acc_step;
  logic              neg_step;
  logic              emit_step;
  logic [7:0]        data_step;
  logic [7:0]        flush_value;

  assign is_digit = (text_byte >= bed_pkg::CH_ZERO) && (text_byte <= bed_pkg::CH_NINE);
  assign is_blank = (text_byte == bed_pkg::CH_SPACE) ||
                    ((text_byte >= bed_pkg::CH_TAB) && (text_byte <= bed_pkg::CH_CR));
  assign digit = text_byte - bed_pkg::CH_ZERO;
  assign close_value = state.neg ? (8'd0 - state.acc) : state.acc;

  // Next mode.
  always_comb begin
    mode_step = state.mode;
    case (state.mode)
      bed_pkg::MODE_OPEN, bed_pkg::MODE_SPACE: begin
        if (state.mode == bed_pkg::MODE_OPEN && text_byte == bed_pkg::CH_OPEN) begin
          mode_step = bed_pkg::MODE_TEXT;
        end else if (text_byte == bed_pkg::CH_CLOSE) begin
          mode_step = bed_pkg::MODE_TEXT;
        end else if (is_blank) begin
          mode_step = bed_pkg::MODE_SPACE;
        end else if (text_byte == bed_pkg::CH_PLUS || text_byte == bed_pkg::CH_MINUS ||
                     is_digit) begin
          mode_step = bed_pkg::MODE_NUMBER;
        end else begin
          mode_step = bed_pkg::MODE_SKIP;
        end
      end
      bed_pkg::MODE_NUMBER: begin
        if (text_byte == bed_pkg::CH_CLOSE) begin
          mode_step = bed_pkg::MODE_TEXT;
        end else if (!is_digit) begin
          mode_step = bed_pkg::MODE_SKIP;
        end
      end
      bed_pkg::MODE_SKIP: begin
        if (text_byte == bed_pkg::CH_CLOSE) begin
          mode_step = bed_pkg::MODE_TEXT;
        end
      end
      default: begin
        mode_step = (text_byte == bed_pkg::CH_OPEN) ? bed_pkg::MODE_OPEN : bed_pkg::MODE_TEXT;
      end
    endcase
  end

  // Accumulator, sign and result.
  always_comb begin
    acc_step  = state.acc;
    neg_step  = state.neg;
    emit_step = 1'b0;
    data_step = text_byte;
    case (state.mode)
      bed_pkg::MODE_OPEN, bed_pkg::MODE_SPACE: begin
        if (state.mode == bed_pkg::MODE_OPEN && text_byte == bed_pkg::CH_OPEN) begin
          emit_step = 1'b1;
          data_step = bed_pkg::CH_OPEN;
          acc_step  = 8'd0;
          neg_step  = 1'b0;
        end else if (text_byte == bed_pkg::CH_CLOSE) begin
          emit_step = 1'b1;
          data_step = close_value;
          acc_step  = 8'd0;
          neg_step  = 1'b0;
        end else if (is_blank || text_byte == bed_pkg::CH_PLUS) begin
          acc_step = state.acc;
        end else if (text_byte == bed_pkg::CH_MINUS) begin
          neg_step = 1'b1;
        end else if (is_digit) begin
          acc_step = digit;
        end
      end
      bed_pkg::MODE_NUMBER: begin
        if (text_byte == bed_pkg::CH_CLOSE) begin
          emit_step = 1'b1;
          data_step = close_value;
          acc_step  = 8'd0;
          neg_step  = 1'b0;
        end else if (is_digit) begin
          // acc * 10 + digit, wrapping at eight bits.
          acc_step = {state.acc[4:0], 3'b000} + {state.acc[6:0], 1'b0} + digit;
        end
      end
      bed_pkg::MODE_SKIP: begin
        if (text_byte == bed_pkg::CH_CLOSE) begin
          emit_step = 1'b1;
          data_step = close_value;
          acc_step  = 8'd0;
          neg_step  = 1'b0;
        end
      end
      default: begin
        if (text_byte == bed_pkg::CH_OPEN) begin
          acc_step = 8'd0;
          neg_step = 1'b0;
        end else begin
          emit_step = 1'b1;
        end
      end
    endcase
  end

  assign flush_value = neg_step ? (8'd0 - acc_step) : acc_step;

  // The final byte of a string closes any escape still open and resets the parser.
  always_comb begin
    if (is_last) begin
      state_next  = bed_pkg::STATE_RESET;
      result.emit = emit_step || (mode_step != bed_pkg::MODE_TEXT);
      result.data = emit_step ? data_step : flush_value;
    end else begin
      state_next.mode = mode_step;
      state_next.acc  = acc_step;
      state_next.neg  = neg_step;
      result.emit     = emit_step;
      result.data     = data_step;
    end
  end

endmodule

`default_nettype wire

>>> verif/bracket_escape_decoder_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the escape decoder, predicts the decoded bytes
// from the accepted requests and compares them with the bytes delivered.
module bracket_escape_decoder_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  input  wire logic       text_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       is_last,
  input  wire logic       data_valid,
  input  wire logic       data_ready,
  input  wire logic [7:0] data_byte,
  output int              mismatch_count,
  output int              bytes_owed
);

  bed_pkg::bed_state_t  parser;
  logic [7:0]           decoded_bytes[$];
  bed_pkg::bed_result_t outcome;
  logic [7:0]           wanted;

  initial begin
    mismatch_count = 0;
    bytes_owed = 0;
  end

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("%0t: %s: got %02h, expected %02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Ends the open escape with its signed value and returns the parser to text.
  function automatic bed_pkg::bed_result_t close_escape();
    bed_pkg::bed_result_t r;
    r.emit = 1'b1;
    r.data = parser.neg ? 8'd0 - parser.acc : parser.acc;
    parser = bed_pkg::STATE_RESET;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= bed_pkg::CH_ZERO && b <= bed_pkg::CH_NINE;
  endfunction

  function automatic bed_pkg::bed_result_t decode_char(input logic [7:0] b, input logic last);
    bed_pkg::bed_result_t r;
    r = '0;
    case (parser.mode)
      bed_pkg::MODE_OPEN, bed_pkg::MODE_SPACE: begin
        if (parser.mode == bed_pkg::MODE_OPEN && b == bed_pkg::CH_OPEN) begin
          r = '{emit: 1'b1, data: bed_pkg::CH_OPEN};
          parser = bed_pkg::STATE_RESET;
        end else if (b == bed_pkg::CH_CLOSE) begin
          r = close_escape();
        end else if (b == bed_pkg::CH_SPACE ||
                     (b >= bed_pkg::CH_TAB && b <= bed_pkg::CH_CR)) begin
          parser.mode = bed_pkg::MODE_SPACE;
        end else if (b == bed_pkg::CH_PLUS) begin
          parser.mode = bed_pkg::MODE_NUMBER;
        end else if (b == bed_pkg::CH_MINUS) begin
          parser.neg = 1'b1;
          parser.mode = bed_pkg::MODE_NUMBER;
        end else if (is_digit(b)) begin
          parser.acc = b - bed_pkg::CH_ZERO;
          parser.mode = bed_pkg::MODE_NUMBER;
        end else begin
          parser.mode = bed_pkg::MODE_SKIP;
        end
      end
      bed_pkg::MODE_NUMBER: begin
        if (b == bed_pkg::CH_CLOSE) begin
          r = close_escape();
        end else if (is_digit(b)) begin
          // Eight-bit arithmetic wraps the magnitude at every digit.
          parser.acc = parser.acc * 8'd10 + (b - bed_pkg::CH_ZERO);
        end else begin
          parser.mode = bed_pkg::MODE_SKIP;
        end
      end
      bed_pkg::MODE_SKIP: begin
        if (b == bed_pkg::CH_CLOSE) r = close_escape();
      end
      default: begin
        if (b == bed_pkg::CH_OPEN) begin
          parser = bed_pkg::STATE_RESET;
          parser.mode = bed_pkg::MODE_OPEN;
        end else begin
          r = '{emit: 1'b1, data: b};
        end
      end
    endcase
    if (last) begin
      if (!r.emit && parser.mode != bed_pkg::MODE_TEXT) r = close_escape();
      parser = bed_pkg::STATE_RESET;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      parser = bed_pkg::STATE_RESET;
      decoded_bytes.delete();
    end else begin
      if (data_valid && data_ready) begin
        if (decoded_bytes.size() == 0) begin
          flag_mismatch("unexpected result", data_byte, 8'h00);
        end else begin
          wanted = decoded_bytes.pop_front();
          if (data_byte !== wanted) flag_mismatch("wrong data_byte", data_byte, wanted);
        end
      end
      if (text_valid && text_ready) begin
        outcome = decode_char(text_byte, is_last);
        if (outcome.emit) decoded_bytes.push_back(outcome.data);
      end
    end
    bytes_owed = decoded_bytes.size();
  end

endmodule

>>> verif/bracket_escape_decoder_unit_test.sv
`timescale 1ns / 100ps

// Test bench for the angle-bracket escape decoder. This module only makes
// stimulus and gives the verdict; the checker beside the block predicts the
// decoded bytes and compares them with what the block delivers.
module bracket_escape_decoder_unit_test;

  localparam int DIRECTED_ITEMS = 26;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_ready;
  logic [7:0] text_byte = 8'h00;
  logic       is_last = 1'b0;
  logic       data_valid;
  logic       data_ready = 1'b0;
  logic [7:0] data_byte;

  int mismatch_count;
  int bytes_owed;
  int items_sent = 0;
  int cycle_count = 0;

  // Chance, in percent, that the sender or the receiver idles in a cycle.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Set while the receiver is held off for a long stretch.
  logic hold_rx = 1'b0;

  bracket_escape_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text_byte (text_byte),
    .is_last   (is_last),
    .data_valid(data_valid),
    .data_ready(data_ready),
    .data_byte (data_byte)
  );

  bracket_escape_decoder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text_byte     (text_byte),
    .is_last       (is_last),
    .data_valid    (data_valid),
    .data_ready    (data_ready),
    .data_byte     (data_byte),
    .mismatch_count(mismatch_count),
    .bytes_owed    (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver decides afresh at every edge whether it takes a result,
  // unless a long hold-off is in progress.
  always @(posedge clk) begin
    data_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  // Long hold-offs of the receiver, counted here, while the sender keeps
  // offering requests. The pipeline fills and the block has to stall its
  // input. One falls in an idling phase, the other where nobody idles.
  initial begin
    wait (items_sent >= 100);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
    wait (items_sent >= DIRECTED_ITEMS + 2 * ITEMS_PER_PHASE + 30);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Guard against a hung block.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Offers one request and returns in the time step of the edge at which it
  // was accepted. Valid is lowered only when a gap is actually inserted, so a
  // back-to-back request keeps valid high without a glitch.
  task automatic offer_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte <= ch;
    is_last <= last;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic offer_text(input string s, input logic ends_string);
    for (int i = 0; i < s.len(); i++) begin
      offer_char(s[i], ends_string && i == s.len() - 1);
    end
  endtask

  initial begin
    logic [7:0] line_q[$];
    logic [7:0] ch;
    int         phase;
    int         piece;
    int         k;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the first idling pattern.
    tx_idle_pct = 33;
    rx_idle_pct = 75;
    // Extremes of the byte range, and a stray closing bracket, pass as text.
    offer_char(8'h00, 1'b0);
    offer_char(8'hFF, 1'b0);
    offer_char(bed_pkg::CH_CLOSE, 1'b0);
    // A doubled bracket gives a literal bracket.
    offer_text("<<", 1'b0);
    // Leading whitespace, a minus sign and a number that wraps past 255.
    offer_text("< \t-300>", 1'b0);
    // A sign with no digits counts as a missing number.
    offer_text("<+>", 1'b0);
    // Trailing junk, an opening bracket included, is dropped up to the close.
    offer_text("<12x<>", 1'b0);
    // An opening bracket on its own at the end of a string gives zero.
    offer_text("<", 1'b1);
    // An escape cut short by the end of the string is flushed.
    offer_text("<-7", 1'b1);

    // Random strings, built from well-formed escapes with random content, plain
    // bytes, doubled brackets, stray closes and escapes left open in their piece.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 75;
        end
        1: begin
          tx_idle_pct = 75;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (items_sent < DIRECTED_ITEMS + (phase + 1) * ITEMS_PER_PHASE) begin
        line_q.delete();
        repeat ($urandom_range(8, 1)) begin
          piece = $urandom_range(99);
          if (piece < 30) begin
            line_q.push_back(8'($urandom_range(255)));
          end else if (piece < 40) begin
            line_q.push_back(bed_pkg::CH_OPEN);
            line_q.push_back(bed_pkg::CH_OPEN);
          end else if (piece < 85) begin
            line_q.push_back(bed_pkg::CH_OPEN);
            repeat ($urandom_range(2)) begin
              k = $urandom_range(6);
              line_q.push_back(k == 6 ? bed_pkg::CH_SPACE : bed_pkg::CH_TAB + 8'(k));
            end
            k = $urandom_range(2);
            if (k == 1) line_q.push_back(bed_pkg::CH_PLUS);
            else if (k == 2) line_q.push_back(bed_pkg::CH_MINUS);
            repeat ($urandom_range(4)) begin
              line_q.push_back(bed_pkg::CH_ZERO + 8'($urandom_range(9)));
            end
            repeat ($urandom_range(2)) begin
              do ch = 8'($urandom_range(255)); while (ch == bed_pkg::CH_CLOSE);
              line_q.push_back(ch);
            end
            line_q.push_back(bed_pkg::CH_CLOSE);
          end else if (piece < 95) begin
            line_q.push_back(bed_pkg::CH_CLOSE);
          end else begin
            // An escape that is opened but not closed within this piece.
            line_q.push_back(bed_pkg::CH_OPEN);
            repeat ($urandom_range(3)) begin
              do ch = 8'($urandom_range(255)); while (ch == bed_pkg::CH_CLOSE);
              line_q.push_back(ch);
            end
          end
        end
        // Now and then the string ends at an arbitrary byte, so that the
        // flush on the last request hits the parser in every mode.
        if ($urandom_range(4) == 0) begin
          k = $urandom_range(line_q.size() - 1);
          while (line_q.size() > k + 1) void'(line_q.pop_back());
        end
        foreach (line_q[i]) offer_char(line_q[i], i == line_q.size() - 1);
      end
    end
    text_valid <= 1'b0;

    // Let every predicted byte arrive, then watch a little longer for any
    // byte that should not come at all.
    while (bytes_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
